@@ rtl/core/sitda_pkg.sv @@
// shared types and constants for the signed integer to decimal text converter
`default_nettype none
package sitda_pkg;

  localparam int MAG_W    = 32;
  localparam int NDIG     = 10;
  localparam int BCD_W    = 4 * NDIG;
  localparam int CNT_W    = $clog2(MAG_W + 1);
  localparam int DLEFT_W  = $clog2(NDIG + 1);
  localparam int CODE_W   = 6;

  localparam logic [CODE_W-1:0] DIGIT_BASE = 6'd48;
  localparam logic [CODE_W-1:0] MINUS_CODE = 6'd45;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic load;
    logic neg;
  } emit_cmd_t;

  // add 3 to every bcd digit of 5 or more before the next doubling
  function automatic logic [BCD_W-1:0] bcd_adjust(input logic [BCD_W-1:0] bcd);
    logic [BCD_W-1:0] res;
    res = bcd;
    for (int i = 0; i < NDIG; i++) begin
      if (bcd[4*i +: 4] >= 4'd5) begin
        res[4*i +: 4] = bcd[4*i +: 4] + 4'd3;
      end
    end
    return res;
  endfunction

endpackage
`default_nettype wire

@@ rtl/core/sitda_dabble.sv @@
// bit-serial shift-and-add-3 binary to bcd converter
`default_nettype none
module sitda_dabble (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       load,
  input  wire logic [sitda_pkg::MAG_W-1:0] mag_in,
  output logic [sitda_pkg::BCD_W-1:0]     bcd,
  output logic                            done
);
  import sitda_pkg::*;

  logic [MAG_W-1:0] mag;
  logic [CNT_W-1:0] cnt;
  logic [BCD_W-1:0] bcd_adj;
  logic [BCD_W-1:0] bcd_next;

  assign done    = (cnt == CNT_W'(MAG_W));
  assign bcd_adj = bcd_adjust(bcd);

  always_comb begin
    bcd_next = {bcd_adj[BCD_W-2:0], mag[MAG_W-1]};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= CNT_W'(MAG_W);
    end else if (load) begin
      cnt <= '0;
    end else if (!done) begin
      cnt <= cnt + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      mag <= mag_in;
      bcd <= '0;
    end else if (!done) begin
      mag <= {mag[MAG_W-2:0], 1'b0};
      bcd <= bcd_next;
    end
  end

endmodule
`default_nettype wire

@@ rtl/core/sitda_emit.sv @@
// character emitter: minus sign for a negative value, then bcd digits one per cycle with leading zeros dropped
`default_nettype none
module sitda_emit (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire sitda_pkg::emit_cmd_t        cmd,
  input  wire logic [sitda_pkg::BCD_W-1:0] bcd_in,
  output logic                             active,
  output logic                             strobe,
  output logic [sitda_pkg::CODE_W-1:0]     char_code,
  output logic                             last
);
  import sitda_pkg::*;

  logic [BCD_W-1:0]   sreg;
  logic [DLEFT_W-1:0] dleft;
  logic               sign_pend;
  logic               seen;
  logic [3:0]         top;
  logic               skip;
  logic               final_dig;

  assign top       = sreg[BCD_W-1 -: 4];
  assign final_dig = (dleft == DLEFT_W'(1));
  assign skip      = (top == 4'd0) && !seen && !final_dig;

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      strobe <= 1'b0;
    end else if (cmd.load) begin
      active <= 1'b1;
      strobe <= 1'b0;
    end else if (active) begin
      strobe <= sign_pend || !skip;
      if (!sign_pend && final_dig) begin
        active <= 1'b0;
      end
    end else begin
      strobe <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      sreg      <= bcd_in;
      dleft     <= DLEFT_W'(NDIG);
      sign_pend <= cmd.neg;
      seen      <= 1'b0;
    end else if (active) begin
      if (sign_pend) begin
        sign_pend <= 1'b0;
        char_code <= MINUS_CODE;
        last      <= 1'b0;
      end else begin
        sreg      <= {sreg[BCD_W-5:0], 4'd0};
        dleft     <= dleft - DLEFT_W'(1);
        seen      <= seen || !skip;
        char_code <= DIGIT_BASE + {2'b00, top};
        last      <= final_dig;
      end
    end
  end

endmodule
`default_nettype wire

@@ rtl/core/signed_int_to_decimal_ascii_core.sv @@
// top level: signed 32-bit integer to decimal ascii character stream
//
// A value is taken on the start/busy command port: a transfer happens at a
// rising edge with start high and busy low. Busy stays high from that edge
// until the last character of the value has been driven out.
// Characters leave on char_code/last, each valid for exactly one cycle while
// strobe is high; the receiver must take every one, it cannot stall.
// A negative value gives a minus sign first; leading zeros are dropped and
// zero gives a single '0'. Last marks the final character of the value.
// The magnitude is converted to bcd one bit per cycle by a
// shift-and-add-3 register; the digits are then handed to the emitter,
// which gives the minus sign first for a negative value and then walks
// the ten bcd digits one per cycle. Each dropped leading zero delays the
// first character. A new transfer is not taken while busy is high, so
// the next value is taken only once the last character is out.
// Reset (rst, synchronous) returns the block to idle and drops any value
// in flight; no character is emitted after reset until a new transfer.
`default_nettype none
module signed_int_to_decimal_ascii_core (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           start,
  input  wire logic signed [31:0]             value,
  output logic                                busy,
  output logic                                strobe,
  output logic [sitda_pkg::CODE_W-1:0]        char_code,
  output logic                                last
);
  import sitda_pkg::*;

  state_t           state;
  state_t           state_next;
  logic             accept;
  logic             neg;
  logic [MAG_W-1:0] mag_in;
  logic [BCD_W-1:0] bcd;
  logic             conv_done;
  logic             emit_active;
  emit_cmd_t        cmd;

  assign accept = start && !busy;
  assign mag_in = value[31] ? (MAG_W'(0) - MAG_W'(value)) : MAG_W'(value);

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (accept) state_next = ST_CONV;
      ST_CONV: if (conv_done) state_next = ST_OUT;
      ST_OUT:  if (!emit_active) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    busy     = (state != ST_IDLE);
    cmd.load = (state == ST_CONV) && conv_done;
    cmd.neg  = neg;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      neg <= value[31];
    end
  end

  sitda_dabble u_dabble (
    .clk    (clk),
    .rst    (rst),
    .load   (accept),
    .mag_in (mag_in),
    .bcd    (bcd),
    .done   (conv_done)
  );

  sitda_emit u_emit (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .bcd_in    (bcd),
    .active    (emit_active),
    .strobe    (strobe),
    .char_code (char_code),
    .last      (last)
  );

`ifndef ASSERT_OFF
  a_strobe_busy: assert property (@(posedge clk) disable iff (rst)
    strobe |-> busy) else $error("character strobed while idle");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    accept |=> busy) else $error("busy not raised after transfer");

  a_last_gap: assert property (@(posedge clk) disable iff (rst)
    (strobe && last) |=> !strobe) else $error("character after last");

  a_conv_quiet: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CONV) |-> !strobe) else $error("character during conversion");
`endif

endmodule
`default_nettype wire
